// ===== src/utf8v_pkg.sv =====
// utf8v_pkg: byte classification types and constants for the UTF-8 sequence validator.
// Standalone; imported by every module of the block.
`timescale 1ns / 1ps
package utf8v_pkg;

	localparam int unsigned PEND_W = 3;

	localparam logic [7:0] ASCII_MASK    = 8'h80;
	localparam logic [7:0] CONT_MASK     = 8'hC0;
	localparam logic [7:0] CONT_TAG      = 8'h80;
	localparam logic [3:0] MIN_LEAD_ONES = 4'd2;

	typedef struct packed {
		logic              non_ascii;
		logic              is_cont;
		logic              lead_ok;
		logic [PEND_W-1:0] lead_pend;
	} byte_class_t;

	function automatic logic [3:0] lead_ones(input logic [7:0] b);
		logic [3:0] n;
		logic       run;
		n   = '0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			run = run & b[i];
			n   = n + {3'b000, run};
		end
		return n;
	endfunction

endpackage

// ===== src/utf8v_lead_decode.sv =====
// utf8v_lead_decode: classifies one string byte as ASCII, continuation or lead byte.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps
module utf8v_lead_decode
	import utf8v_pkg::*;
#(
	parameter int MAX_SEQUENCE_LEN = 6
) (
	input  logic [7:0]  data_byte,
	output byte_class_t cls
);

	logic [3:0] ones;

	always_comb begin
		ones          = lead_ones(data_byte);
		cls.non_ascii = (data_byte & ASCII_MASK) != 8'h00;
		cls.is_cont   = (data_byte & CONT_MASK) == CONT_TAG;
		cls.lead_ok   = (ones >= MIN_LEAD_ONES) && (ones <= 4'(MAX_SEQUENCE_LEN));
		cls.lead_pend = PEND_W'(ones - 4'd1);
	end

endmodule

// ===== src/utf8v_scan_state.sv =====
// utf8v_scan_state: per-string state (continuations due, error, non-ASCII) and verdict.
// Depends on utf8v_pkg.
`timescale 1ns / 1ps
module utf8v_scan_state
	import utf8v_pkg::*;
#(
	parameter int MAX_SEQUENCE_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        last,
	input  byte_class_t cls,
	output logic        verdict
);

	logic [PEND_W-1:0] pending_q, pending_d;
	logic              bad_q, bad_d;
	logic              nas_q, nas_d;

	always_comb begin
		pending_d = pending_q;
		bad_d     = bad_q;
		nas_d     = nas_q | cls.non_ascii;
		if (!bad_q) begin
			if (pending_q == '0) begin
				if (cls.non_ascii) begin
					if (cls.lead_ok) begin
						pending_d = cls.lead_pend;
					end else begin
						bad_d = 1'b1;
					end
				end
			end else begin
				if (cls.is_cont) begin
					pending_d = pending_q - PEND_W'(1);
				end else begin
					bad_d = 1'b1;
				end
			end
		end
		verdict = !bad_d && nas_d && (pending_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			bad_q     <= 1'b0;
			nas_q     <= 1'b0;
		end else if (advance) begin
			if (last) begin
				pending_q <= '0;
				bad_q     <= 1'b0;
				nas_q     <= 1'b0;
			end else begin
				pending_q <= pending_d;
				bad_q     <= bad_d;
				nas_q     <= nas_d;
			end
		end
	end

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_W'(MAX_SEQUENCE_LEN - 1))
		else $error("continuation count beyond longest sequence");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> pending_q == '0 && !bad_q && !nas_q)
		else $error("state not cleared after last byte");

	a_bad_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		bad_q && advance && !last |=> bad_q && $stable(pending_q))
		else $error("error flag or count moved after error");

	a_verdict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		verdict |-> nas_d && !bad_d)
		else $error("pass verdict with error or all-ASCII string");

endmodule

// ===== src/utf8_sequence_validator_unit.sv =====
// utf8_sequence_validator_unit: top level of the lenient UTF-8 string validator.
// Depends on utf8v_pkg, utf8v_lead_decode and utf8v_scan_state.
//
//  channel  handshake            payload          direction
//  in       in_valid / in_stall  data_byte, last  one byte of a string per transaction
//  out      out_valid/ out_stall is_utf8          one verdict per string, on its last byte
//
// One byte per cycle sustained, unless a last byte must wait for a stalled verdict.
// Input register, then decode and state update, then the verdict register.
// A stalled verdict holds in its register; a last byte waits in the input register,
// while bytes that are not last keep flowing.
// Reset clears the string state and both valid flags.
`timescale 1ns / 1ps
module utf8_sequence_validator_unit
	import utf8v_pkg::*;
#(
	parameter int MAX_SEQUENCE_LEN = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_utf8
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic        is_utf8_q;
	logic        out_free;
	logic        s1_fire;
	logic        in_take;
	logic        verdict;
	byte_class_t cls;

	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !s1_fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	utf8v_lead_decode #(
		.MAX_SEQUENCE_LEN(MAX_SEQUENCE_LEN)
	) u_decode (
		.data_byte(data_s1),
		.cls      (cls)
	);

	utf8v_scan_state #(
		.MAX_SEQUENCE_LEN(MAX_SEQUENCE_LEN)
	) u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(s1_fire),
		.last   (last_s1),
		.cls    (cls),
		.verdict(verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_fire && last_s1) begin
			is_utf8_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_utf8   = is_utf8_q;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("waiting byte dropped or changed");

	a_last_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> out_valid_q)
		else $error("verdict lost");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && last_s1))
		else $error("verdict without last byte");

endmodule

// ===== tb/utf8_sequence_validator_unit_tb.sv =====
// utf8_sequence_validator_unit_tb: self-checking bench for the lenient UTF-8 string validator.
// Drives byte strings through the valid/stall channels and scores every verdict.
// Depends on utf8v_pkg and utf8_sequence_validator_unit.
`timescale 1ns / 1ps
module utf8_sequence_validator_unit_tb;
	import utf8v_pkg::*;

	localparam int MAX_SEQ          = 6;
	localparam int RANDOM_BYTES     = 1000;
	localparam int CALM_TAIL        = 150;
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES     = 8;
	localparam int LIMIT_CYCLES     = 200000;

	class string_verdict_tracker;
		logic [2:0] pend;
		bit         bad;
		bit         non_ascii;
		bit         due_verdicts[$];

		function new();
			clear();
		endfunction

		function void clear();
			pend      = '0;
			bad       = 1'b0;
			non_ascii = 1'b0;
		endfunction

		function int unsigned lead_count(logic [7:0] b);
			casez (b)
				8'b0???????: return 0;
				8'b10??????: return 1;
				8'b110?????: return 2;
				8'b1110????: return 3;
				8'b11110???: return 4;
				8'b111110??: return 5;
				8'b1111110?: return 6;
				8'b11111110: return 7;
				default:     return 8;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic is_last);
			int unsigned n;
			if ((b & ASCII_MASK) != 0)
				non_ascii = 1'b1;
			if (!bad) begin
				if (pend == 0) begin
					if ((b & ASCII_MASK) != 0) begin
						n = lead_count(b);
						if (n < MIN_LEAD_ONES || n > MAX_SEQ)
							bad = 1'b1;
						else
							pend = 3'(n - 1);
					end
				end else begin
					if ((b & CONT_MASK) != CONT_TAG)
						bad = 1'b1;
					else
						pend = pend - 3'd1;
				end
			end
			if (is_last) begin
				due_verdicts.push_back(!bad && non_ascii && pend == 0);
				clear();
			end
		endfunction

		function bit check_verdict(logic got, output string why);
			bit want;
			if (due_verdicts.size() == 0) begin
				why = $sformatf("is_utf8=%b with no string outstanding", got);
				return 1'b0;
			end
			want = due_verdicts.pop_front();
			if (got !== want) begin
				why = $sformatf("is_utf8 got %b want %b", got, want);
				return 1'b0;
			end
			why = "";
			return 1'b1;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       last;
	logic       out_valid;
	logic       out_stall;
	logic       is_utf8;

	int cycle_count   = 0;
	int mismatches    = 0;
	int bytes_sent    = 0;
	bit bursty        = 1'b0;
	bit long_hold_due = 1'b0;

	string_verdict_tracker tracker = new();

	utf8_sequence_validator_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.last     (last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_utf8  (is_utf8)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("utf8_sequence_validator_unit_tb failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string why);
		$display("MISMATCH cycle %0d: %s", cycle_count, why);
		mismatches++;
	endtask

	always @(posedge clk) begin : watch_verdicts
		string why;
		if (arst_n && out_valid && !out_stall) begin
			if (!tracker.check_verdict(is_utf8, why))
				report_mismatch(why);
		end
	end

	initial begin : drive_out_stall
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				hold = LONG_HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (bursty && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		if (bursty && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last      <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_byte(b, is_last);
		bytes_sent++;
	endtask

	task automatic send_string(input logic [7:0] s[$]);
		for (int i = 0; i < s.size(); i++)
			send_byte(s[i], i == s.size() - 1);
	endtask

	function automatic logic [7:0] lead_byte(input int unsigned ones);
		logic [7:0] fixed;
		logic [7:0] free;
		if (ones == 0)
			return 8'($urandom_range(1, 127));
		fixed = 8'hFF << (8 - ones);
		free  = 8'hFF >> (ones + 1);
		return fixed | (8'($urandom) & free);
	endfunction

	function automatic void put_char(ref logic [7:0] s[$], input int unsigned ones);
		s.push_back(lead_byte(ones));
		for (int i = 1; i < ones; i++)
			s.push_back(8'h80 | (8'($urandom) & 8'h3F));
	endfunction

	task automatic build_random_string(output logic [7:0] s[$]);
		int         kind;
		int         chars;
		int         pos;
		int         bad_ones;
		logic [7:0] tmp[$];
		kind = $urandom_range(0, 99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 8))
				tmp.push_back(8'($urandom_range(1, 255)));
		end else if (kind >= 55 && kind < 65) begin
			repeat ($urandom_range(1, 6))
				put_char(tmp, 0);
		end else begin
			chars = $urandom_range(1, 6);
			repeat (chars)
				put_char(tmp, $urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, MAX_SEQ));
			if (kind >= 65) begin
				pos = $urandom_range(0, tmp.size() - 1);
				case ($urandom_range(0, 3))
					0: tmp[pos] = 8'($urandom_range(1, 255));
					1: if (tmp.size() > 1) tmp.pop_back();
					2: tmp.push_back(lead_byte($urandom_range(2, MAX_SEQ)));
					default: begin
						bad_ones = $urandom_range(0, 2) == 0 ? 1 : $urandom_range(7, 8);
						tmp.insert(pos, lead_byte(bad_ones));
					end
				endcase
			end
		end
		s = tmp;
	endtask

	initial begin : run_stimulus
		logic [7:0] str[$];
		bit         long_done;
		int         random_start;
		in_valid  = 1'b0;
		data_byte = 8'h01;
		last      = 1'b0;
		arst_n    = 1'b0;
		long_done = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		bursty = 1'b1;
		str = '{8'h01};                                     send_string(str);
		str = '{8'h7F};                                     send_string(str);
		str = '{8'hC3, 8'hA9};                              send_string(str);
		str = '{8'h80};                                     send_string(str);
		str = '{8'hFE};                                     send_string(str);
		str = '{8'hFF};                                     send_string(str);
		str = '{8'hFC, 8'h80, 8'hBF, 8'h80, 8'hBF, 8'h80}; send_string(str);
		str = '{8'hE2, 8'h82};                              send_string(str);
		str = '{8'hC3, 8'h41};                              send_string(str);
		str = '{8'hC3, 8'hC3};                              send_string(str);
		str = '{8'h41, 8'hF0, 8'h9F, 8'h98, 8'h80};         send_string(str);

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			bursty = (bytes_sent - random_start < RANDOM_BYTES - CALM_TAIL)
				&& ($urandom_range(0, 3) != 0);
			if (!long_done && bytes_sent - random_start >= LONG_HOLD_AT) begin
				long_hold_due = 1'b1;
				long_done = 1'b1;
			end
			build_random_string(str);
			send_string(str);
		end
		bursty = 1'b0;
		in_valid <= 1'b0;

		while (tracker.due_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("utf8_sequence_validator_unit_tb passed");
		else
			$display("utf8_sequence_validator_unit_tb failed");
		$finish;
	end

endmodule
